### hdl/keyboard_wavetable_synth_core_assert.svh
`ifndef KEYBOARD_WAVETABLE_SYNTH_CORE_ASSERT_SVH
`define KEYBOARD_WAVETABLE_SYNTH_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define KWS_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define KWS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/kws_pkg.sv
package kws_pkg;

    localparam int TABLE_LEN_DEF   = 48000;
    localparam int VOICES_DEF      = 8;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int VOLUME_MAX_DEF  = 15;

    localparam int NUM_FREQ  = 8;
    localparam int VIDX_W    = 3;
    localparam int FREQ_W    = 17;
    localparam int CFG_IDX_W = 4;
    localparam int CODE_W    = 8;
    localparam int OUT_W     = 32;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CODE_W-1:0] BREAK_CODE    = 8'hF0;
    localparam logic [CODE_W-1:0] VOL_UP_CODE   = 8'h32;
    localparam logic [CODE_W-1:0] VOL_DOWN_CODE = 8'h21;

    localparam logic [CODE_W-1:0] KEY_CODE [NUM_FREQ] = '{
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h3B, 8'h42, 8'h4B, 8'h4C
    };

    localparam logic [FREQ_W-1:0] FREQ_RESET [NUM_FREQ] = '{
        17'd33488, 17'd37589, 17'd42192, 17'd44701,
        17'd50175, 17'd56320, 17'd63217, 17'd66976
    };

    typedef struct packed {
        logic              key_apply;
        logic              tick_start;
        logic              issue;
        logic [VIDX_W-1:0] voice;
        logic              load_out;
    } cmd_t;

endpackage

### hdl/kws_ctrl.sv
module kws_ctrl #(
    parameter int VOICES = kws_pkg::VOICES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_command,
    output logic          m_valid,
    input  logic          m_ready,
    output kws_pkg::cmd_t cmd
);
    import kws_pkg::*;

    localparam int LAST  = VOICES + 8;
    localparam int CNT_W = $clog2(LAST + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               accept;
    logic               load;

    always_comb begin
        accept       = s_valid && (state_reg == ST_IDLE);
        load         = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_command == CMD_TICK)) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN: begin
                if (cnt_reg == CNT_W'(LAST)) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (load) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign cmd.key_apply  = accept && (s_command == CMD_KEY);
    assign cmd.tick_start = accept && (s_command == CMD_TICK);
    assign cmd.issue      = (state_reg == ST_RUN) && (cnt_reg < CNT_W'(VOICES));
    assign cmd.voice      = cnt_reg[VIDX_W-1:0];
    assign cmd.load_out   = load;

endmodule

### hdl/kws_dp.sv
module kws_dp #(
    parameter int TABLE_LEN   = kws_pkg::TABLE_LEN_DEF,
    parameter int VOICES      = kws_pkg::VOICES_DEF,
    parameter int SAMPLE_BITS = kws_pkg::SAMPLE_BITS_DEF,
    parameter int VOLUME_MAX  = kws_pkg::VOLUME_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kws_pkg::cmd_t                      cmd,
    input  logic [kws_pkg::CODE_W-1:0]         s_scan_code,
    input  logic                               cfg_valid,
    input  logic [kws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kws_pkg::FREQ_W-1:0]         cfg_data,
    output logic signed [kws_pkg::OUT_W-1:0]   m_sample
);
    import kws_pkg::*;

    localparam int TW    = $clog2(TABLE_LEN);
    localparam int PW    = FREQ_W + TW;
    localparam int XW    = PW - 8;
    localparam int RW    = 10;
    localparam int QW    = 10;
    localparam int RECIP = (2 ** XW) / TABLE_LEN;
    localparam int SB    = SAMPLE_BITS;
    localparam int SUM_W = SB + $clog2(VOICES) + 1;
    localparam int VOL_W = $clog2(VOLUME_MAX + 1);
    localparam int MUL_W = SUM_W + VOL_W + 1;
    localparam int EXT_W = (MUL_W > OUT_W) ? MUL_W : OUT_W + 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [EXT_W-1:0] SAT_MAX =
        {{(EXT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_MIN =
        {{(EXT_W - OUT_W){1'b1}}, 1'b1, {(OUT_W - 1){1'b0}}};

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] sub;
        x2  = (x * x) >> 30;
        acc = 64'd1 << 30;
        for (int k = 0; k < 6; k++) begin
            sub = (x2 * acc) >> 30;
            case (k)
                0:       sub = sub / 156;
                1:       sub = sub / 110;
                2:       sub = sub / 72;
                3:       sub = sub / 42;
                4:       sub = sub / 20;
                default: sub = sub / 6;
            endcase
            acc = (sub >= acc) ? 64'd0 : acc - sub;
        end
        return (x * acc) >> 30;
    endfunction

    function automatic logic signed [SB-1:0] sine_entry(input int i);
        logic [63:0] n;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] amp;
        logic [63:0] mag;
        amp  = (64'd1 << (SB - 1)) - 64'd1;
        n    = 64'(i) * 64'd4;
        quad = n / TABLE_LEN;
        rem  = n % TABLE_LEN;
        r    = quad[0] ? 64'(TABLE_LEN) - rem : rem;
        x    = (HALF_PI_Q30 * r) / TABLE_LEN;
        s    = sin_q30(x);
        mag  = (s * amp + (64'd1 << 29)) >> 30;
        if (mag > amp) begin
            mag = amp;
        end
        return quad[1] ? SB'(-mag) : SB'(mag);
    endfunction

    logic signed [SB-1:0] sine_rom [TABLE_LEN];

    initial begin
        for (int i = 0; i < TABLE_LEN; i++) begin
            sine_rom[i] = sine_entry(i);
        end
    end

    logic [FREQ_W-1:0]   freq_reg [NUM_FREQ];
    logic [NUM_FREQ-1:0] voice_on_reg;
    logic                armed_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic [TW-1:0]       t_reg;
    logic [NUM_FREQ-1:0] key_hit;

    always_comb begin
        for (int i = 0; i < NUM_FREQ; i++) begin
            key_hit[i] = (s_scan_code == KEY_CODE[i]) && (i < VOICES);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_FREQ; i++) begin
            if (!aresetn) begin
                freq_reg[i] <= FREQ_RESET[i];
            end else if (cfg_valid && (cfg_index == CFG_IDX_W'(i))) begin
                freq_reg[i] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_on_reg <= '0;
            armed_reg    <= 1'b0;
            vol_reg      <= VOL_W'(1);
            t_reg        <= '0;
        end else begin
            if (cmd.key_apply) begin
                armed_reg    <= (s_scan_code == BREAK_CODE);
                voice_on_reg <= armed_reg ? (voice_on_reg & ~key_hit)
                                          : (voice_on_reg | key_hit);
                if (armed_reg && (s_scan_code == VOL_UP_CODE)
                        && (vol_reg < VOL_W'(VOLUME_MAX))) begin
                    vol_reg <= vol_reg + 1'b1;
                end
                if (armed_reg && (s_scan_code == VOL_DOWN_CODE) && (vol_reg != '0)) begin
                    vol_reg <= vol_reg - 1'b1;
                end
            end
            if (cmd.load_out) begin
                t_reg <= (t_reg == TW'(TABLE_LEN - 1)) ? '0 : t_reg + 1'b1;
            end
        end
    end

    logic [FREQ_W-1:0]      freq_sel;
    logic                   en_sel;
    logic [XW+RW-1:0]       xr;
    logic [XW-1:0]          rdiff;
    logic [TW:0]            r_raw;
    logic [TW:0]            r_fix;
    logic [TW-1:0]          idx;
    logic signed [SB+9:0]   v_full;
    logic signed [SB-1:0]   v_val;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [PW-1:0]          p1_reg;
    logic [XW-1:0]          x2_reg, x3_reg;
    logic [QW-1:0]          q2_reg;
    logic [XW-1:0]          qt3_reg;
    logic [7:0]             f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    logic [TW-1:0]          idx4_reg, nxt4_reg;
    logic signed [SB-1:0]   a5_reg, b5_reg, a6_reg, a7_reg;
    logic signed [SB:0]     d6_reg;
    logic signed [SB+9:0]   m7_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [MUL_W-1:0] scaled_reg;
    logic signed [EXT_W-1:0] ext;
    logic signed [VOL_W:0]  vol_s;
    logic signed [OUT_W-1:0] sat_reg;
    logic signed [OUT_W-1:0] m_sample_reg;

    always_comb begin
        freq_sel = freq_reg[cmd.voice];
        en_sel   = cmd.issue && voice_on_reg[cmd.voice];
        xr       = (XW + RW)'(p1_reg[PW-1:8]) * (XW + RW)'(RECIP);
        rdiff    = x3_reg - qt3_reg;
        r_raw    = rdiff[TW:0];
        r_fix    = (r_raw >= (TW + 1)'(TABLE_LEN)) ? r_raw - (TW + 1)'(TABLE_LEN) : r_raw;
        idx      = r_fix[TW-1:0];
        v_full   = $signed({{2{a7_reg[SB-1]}}, a7_reg, 8'b0}) + m7_reg;
        v_val    = v_full[SB+7:8];
        vol_s    = $signed({1'b0, vol_reg});
        ext      = EXT_W'(scaled_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            v1_reg <= en_sel;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg   <= PW'(freq_sel) * PW'(t_reg);

        x2_reg   <= p1_reg[PW-1:8];
        f2_reg   <= p1_reg[7:0];
        q2_reg   <= xr[XW +: QW];

        qt3_reg  <= XW'(q2_reg) * XW'(TABLE_LEN);
        x3_reg   <= x2_reg;
        f3_reg   <= f2_reg;

        idx4_reg <= idx;
        nxt4_reg <= (idx == TW'(TABLE_LEN - 1)) ? '0 : idx + 1'b1;
        f4_reg   <= f3_reg;

        a5_reg   <= sine_rom[idx4_reg];
        b5_reg   <= sine_rom[nxt4_reg];
        f5_reg   <= f4_reg;

        d6_reg   <= {b5_reg[SB-1], b5_reg} - {a5_reg[SB-1], a5_reg};
        a6_reg   <= a5_reg;
        f6_reg   <= f5_reg;

        m7_reg   <= $signed({1'b0, f6_reg}) * d6_reg;
        a7_reg   <= a6_reg;

        if (cmd.tick_start) begin
            acc_reg <= '0;
        end else if (v7_reg) begin
            acc_reg <= acc_reg + SUM_W'(v_val);
        end

        scaled_reg <= MUL_W'(acc_reg) * MUL_W'(vol_s);

        if (ext > SAT_MAX) begin
            sat_reg <= SAT_MAX[OUT_W-1:0];
        end else if (ext < SAT_MIN) begin
            sat_reg <= SAT_MIN[OUT_W-1:0];
        end else begin
            sat_reg <= ext[OUT_W-1:0];
        end

        if (cmd.load_out) begin
            m_sample_reg <= sat_reg;
        end
    end

    assign m_sample = m_sample_reg;

endmodule

### hdl/keyboard_wavetable_synth_core.sv
// Eight-voice keyboard wavetable synthesizer.
// Input channel (s_valid/s_ready): s_command 0 carries a PS/2 set 2 scan code
// byte in s_scan_code, s_command 1 is a sample tick. Scan codes turn voices on
// and off, 0xF0 arms a release, and volume keys step the volume on release.
// Result channel (m_valid/m_ready): one m_sample per tick, none per scan code.
// Config channel (cfg_valid/cfg_ready): cfg_index 0..7 sets the Q9.8 frequency
// of that voice; other indexes are ignored. Always ready; write only when idle.
// A scan code is applied when accepted and the block stays ready.
// A tick streams the voices one per cycle through a phase, table read and
// interpolation pipeline, then scales and saturates into the output
// register; the block takes no new item until that result is registered.
// The output register holds a result until taken; scan codes and the next
// tick's work proceed meanwhile, and a finished tick waits for the register.
// Reset turns all voices off, sets volume to one, sample time to zero and the
// frequencies to their defaults. The sine table is a read-only ROM.
module keyboard_wavetable_synth_core #(
    parameter int TABLE_LEN   = kws_pkg::TABLE_LEN_DEF,
    parameter int VOICES      = kws_pkg::VOICES_DEF,
    parameter int SAMPLE_BITS = kws_pkg::SAMPLE_BITS_DEF,
    parameter int VOLUME_MAX  = kws_pkg::VOLUME_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [kws_pkg::CODE_W-1:0]       s_scan_code,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [kws_pkg::OUT_W-1:0] m_sample,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kws_pkg::FREQ_W-1:0]       cfg_data
);
    import kws_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    kws_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    kws_dp #(
        .TABLE_LEN   (TABLE_LEN),
        .VOICES      (VOICES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .VOLUME_MAX  (VOLUME_MAX)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_scan_code (s_scan_code),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_sample    (m_sample)
    );

endmodule

### hdl/kws_checker.sv
module kws_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_command,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [kws_pkg::OUT_W-1:0] m_sample
);
`include "keyboard_wavetable_synth_core_assert.svh"

    `KWS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_sample), "result changed while stalled")
    `KWS_ASSERT_NEXT(a_tick_busy, s_valid && s_ready && s_command, !s_ready, "tick did not occupy the block")
    `KWS_ASSERT_NEXT(a_key_free, s_valid && s_ready && !s_command, s_ready, "scan code stalled the input")
    `KWS_ASSERT_IMPL(a_out_after_work, $rose(m_valid), $past(!s_ready), "result without tick work")

endmodule

bind keyboard_wavetable_synth_core kws_checker u_kws_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_command (s_command),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_sample  (m_sample)
);

### test/tb_keyboard_wavetable_synth_core.sv
`timescale 1ns / 1ps

module tb_keyboard_wavetable_synth_core;
    import kws_pkg::*;

    localparam int TABLE_LEN     = TABLE_LEN_DEF;
    localparam int VOICES        = VOICES_DEF;
    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int VOLUME_MAX    = VOLUME_MAX_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 4'd15;
    localparam logic [FREQ_W-1:0]    FREQ_MAX     = '1;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SINE_AMP    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam int TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic                    s_command   = CMD_KEY;
    logic [CODE_W-1:0]       s_scan_code = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic signed [OUT_W-1:0] m_sample;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [FREQ_W-1:0]       cfg_data    = '0;

    logic [FREQ_W-1:0]       voice_freq [NUM_FREQ];
    logic [FREQ_W-1:0]       freq_plan [NUM_FREQ];
    logic [NUM_FREQ-1:0]     gate_mask;
    bit                      break_pending;
    int                      gain;
    int                      phase_clock;
    int                      sine_lut [TABLE_LEN];
    logic signed [OUT_W-1:0] expected_samples [$];

    int send_idle_pct = 13;
    int recv_idle_pct = 50;
    int items_sent    = 0;
    int fail_count    = 0;

    keyboard_wavetable_synth_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_scan_code (s_scan_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 aclk = ~aclk;

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : build_sine_lut
        longint unsigned n, quad, rem, r, x, x2, acc, sub, s, mag;
        int i, k;
        for (i = 0; i < TABLE_LEN; i++) begin
            n    = 64'(4 * i);
            quad = n / TABLE_LEN;
            rem  = n % TABLE_LEN;
            r    = quad[0] ? TABLE_LEN - rem : rem;
            x    = HALF_PI_Q30 * r / TABLE_LEN;
            x2   = (x * x) >> 30;
            acc  = Q30_ONE;
            for (k = 0; k < 6; k++) begin
                sub = ((x2 * acc) >> 30) / TAYLOR_DIV[k];
                acc = (sub >= acc) ? 64'd0 : acc - sub;
            end
            s   = (x * acc) >> 30;
            mag = (s * SINE_AMP + (64'd1 << 29)) >> 30;
            if (mag > SINE_AMP) begin
                mag = SINE_AMP;
            end
            sine_lut[i] = quad[1] ? -int'(mag) : int'(mag);
        end
    end

    function automatic void flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic void advance_synth(input logic cmd, input logic [CODE_W-1:0] code);
        int hit, v, j, idx, nxt;
        longint sum, level, frac;
        longint unsigned p;
        hit = -1;
        sum = 0;
        if (cmd == CMD_TICK) begin
            for (v = 0; v < VOICES; v++) begin
                if (gate_mask[v]) begin
                    p = (64'(voice_freq[v]) * 64'(phase_clock)) % (64'(TABLE_LEN) * 64'd256);
                    idx   = int'(p >> 8);
                    frac  = longint'(p & 64'd255);
                    nxt   = (idx + 1 >= TABLE_LEN) ? 0 : idx + 1;
                    level = (256 - frac) * sine_lut[idx] + frac * sine_lut[nxt];
                    sum  += level >>> 8;
                end
            end
            sum *= gain;
            if (sum > 64'sd2147483647) begin
                sum = 64'sd2147483647;
            end else if (sum < -64'sd2147483648) begin
                sum = -64'sd2147483648;
            end
            expected_samples.push_back(OUT_W'(sum));
            phase_clock = (phase_clock + 1 >= TABLE_LEN) ? 0 : phase_clock + 1;
        end else if (code == BREAK_CODE) begin
            break_pending = 1'b1;
        end else begin
            for (j = 0; j < NUM_FREQ; j++) begin
                if (code == KEY_CODE[j]) begin
                    hit = j;
                end
            end
            if (hit >= 0) begin
                if (hit < VOICES) begin
                    gate_mask[hit] = !break_pending;
                end
                break_pending = 1'b0;
            end else if (code == VOL_UP_CODE || code == VOL_DOWN_CODE) begin
                if (break_pending) begin
                    if (code == VOL_UP_CODE && gain < VOLUME_MAX) begin
                        gain++;
                    end else if (code == VOL_DOWN_CODE && gain > 0) begin
                        gain--;
                    end
                    break_pending = 1'b0;
                end
            end else begin
                break_pending = 1'b0;
            end
        end
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_samples
        logic signed [OUT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                flag_error($sformatf("unexpected sample %0d", m_sample));
            end else begin
                want = expected_samples.pop_front();
                if (m_sample !== want) begin
                    flag_error($sformatf("sample mismatch: expected %0d, got %0d",
                                         want, m_sample));
                end
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_scan_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        advance_synth(cmd, code);
    endtask

    task automatic release_key(input logic [CODE_W-1:0] code);
        send_item(CMD_KEY, BREAK_CODE);
        send_item(CMD_KEY, code);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < NUM_FREQ) begin
            voice_freq[idx] = data;
        end
    endtask

    task automatic program_freqs(input bit with_spare);
        int v;
        wait_idle();
        for (v = 0; v < NUM_FREQ; v++) begin
            write_reg(CFG_IDX_W'(v), freq_plan[v]);
        end
        if (with_spare) begin
            write_reg(SPARE_IDX_LO, FREQ_W'($urandom));
            write_reg(SPARE_IDX_HI, FREQ_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan_random_freqs();
        int v;
        for (v = 0; v < NUM_FREQ; v++) begin
            case ($urandom_range(9))
                0: freq_plan[v] = '0;
                1: freq_plan[v] = FREQ_MAX;
                2: freq_plan[v] = FREQ_RESET[v];
                default: freq_plan[v] = FREQ_W'($urandom);
            endcase
        end
    endfunction

    task automatic test_key_handling();
        int v;
        send_idle_pct = 13;
        recv_idle_pct = 50;
        send_item(CMD_TICK, 8'h00);
        release_key(VOL_UP_CODE);
        for (v = 0; v < NUM_FREQ; v++) begin
            send_item(CMD_KEY, KEY_CODE[v]);
        end
        send_item(CMD_TICK, 8'hFF);
        release_key(KEY_CODE[0]);
        release_key(VOL_DOWN_CODE);
        send_item(CMD_KEY, VOL_UP_CODE);
        send_item(CMD_KEY, VOL_DOWN_CODE);
        send_item(CMD_KEY, BREAK_CODE);
        release_key(KEY_CODE[1]);
        send_item(CMD_TICK, 8'h5A);
        release_key(8'h00);
        send_item(CMD_KEY, KEY_CODE[2]);
        send_item(CMD_KEY, 8'hFF);
        send_item(CMD_TICK, 8'hA5);
    endtask

    task automatic test_freq_extremes();
        int v;
        send_idle_pct = 50;
        recv_idle_pct = 13;
        for (v = 0; v < NUM_FREQ; v++) begin
            freq_plan[v] = v[0] ? FREQ_MAX : '0;
        end
        program_freqs(1'b1);
        for (v = 0; v < NUM_FREQ; v++) begin
            send_item(CMD_KEY, KEY_CODE[v]);
        end
        repeat (3) send_item(CMD_TICK, 8'($urandom));
        for (v = 0; v < NUM_FREQ; v++) begin
            freq_plan[v] = v[0] ? '0 : FREQ_MAX;
        end
        program_freqs(1'b1);
        repeat (3) send_item(CMD_TICK, 8'($urandom));
    endtask

    task automatic run_random_phase(input int n_items);
        int stop_at, choice, reps;
        logic [CODE_W-1:0] vol_code;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            choice = $urandom_range(99);
            if (choice < 35) begin
                send_item(CMD_TICK, 8'($urandom));
            end else if (choice < 50) begin
                send_item(CMD_KEY, KEY_CODE[$urandom_range(NUM_FREQ - 1)]);
            end else if (choice < 62) begin
                release_key(KEY_CODE[$urandom_range(NUM_FREQ - 1)]);
            end else if (choice < 70) begin
                // run the volume into its limits
                vol_code = $urandom_range(1) ? VOL_UP_CODE : VOL_DOWN_CODE;
                reps = $urandom_range(18, 1);
                repeat (reps) release_key(vol_code);
                send_item(CMD_TICK, 8'($urandom));
            end else if (choice < 80) begin
                send_item(CMD_KEY, 8'($urandom));
            end else if (choice < 88) begin
                release_key(8'($urandom));
            end else if (choice < 94) begin
                // hold the break prefix across a tick
                send_item(CMD_KEY, BREAK_CODE);
                send_item(CMD_TICK, 8'($urandom));
                send_item(CMD_KEY, $urandom_range(1) ? VOL_UP_CODE
                                                     : KEY_CODE[$urandom_range(NUM_FREQ - 1)]);
            end else begin
                send_item(CMD_KEY, $urandom_range(1) ? VOL_DOWN_CODE : BREAK_CODE);
                release_key(KEY_CODE[$urandom_range(NUM_FREQ - 1)]);
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 13;
        recv_idle_pct = 50;
        plan_random_freqs();
        program_freqs(1'b0);
        run_random_phase(500);
        send_idle_pct = 50;
        recv_idle_pct = 13;
        plan_random_freqs();
        program_freqs(1'b1);
        run_random_phase(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        plan_random_freqs();
        program_freqs(1'b0);
        run_random_phase(500);
    endtask

    task automatic test_full_chord();
        int v;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        plan_random_freqs();
        program_freqs(1'b0);
        for (v = 0; v < NUM_FREQ; v++) begin
            send_item(CMD_KEY, KEY_CODE[v]);
        end
        // drive the volume to its ceiling and one step past it
        while (gain < VOLUME_MAX) begin
            release_key(VOL_UP_CODE);
        end
        release_key(VOL_UP_CODE);
        repeat (16) send_item(CMD_TICK, 8'($urandom));
    endtask

    initial begin : main_seq
        int v;
        for (v = 0; v < NUM_FREQ; v++) begin
            voice_freq[v] = FREQ_RESET[v];
        end
        gate_mask     = '0;
        break_pending = 1'b0;
        gain          = 1;
        phase_clock   = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_key_handling();
        test_freq_extremes();
        test_random_traffic();
        test_full_chord();
        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/kws_pkg.sv
hdl/kws_ctrl.sv
hdl/kws_dp.sv
hdl/keyboard_wavetable_synth_core.sv
hdl/kws_checker.sv
test/tb_keyboard_wavetable_synth_core.sv
